/* src/min_tracking_stack_assert.svh */
// Assertion macros for the min tracking stack.
// Each expects aclk and aresetn in scope.
`ifndef MIN_TRACKING_STACK_ASSERT_SVH
`define MIN_TRACKING_STACK_ASSERT_SVH

// Same-cycle implication
`define MIN_STK_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("min stack check failed");

// Next-cycle implication
`define MIN_STK_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("min stack check failed");

`endif

/* src/min_stk_pkg.sv */
package min_stk_pkg;

    // Command codes
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_TOP  = 2'd2;
    localparam logic [1:0] CMD_MIN  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] push_value;
    } min_stk_req_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
    } min_stk_res_t;

endpackage

/* src/min_stk_mem.sv */
module min_stk_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [31:0]              wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [31:0]              rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    // Single write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/min_stk_ctrl.sv */
`include "min_tracking_stack_assert.svh"

module min_stk_ctrl #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  min_stk_pkg::min_stk_req_t      req,
    input  logic                           out_free,
    output logic                           res_valid,
    output min_stk_pkg::min_stk_res_t      res,
    output logic                           val_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] val_wr_addr,
    output logic                           min_wr_en,
    output logic [$clog2(STACK_DEPTH)-1:0] min_wr_addr,
    output logic                           rd_en,
    output logic [$clog2(STACK_DEPTH)-1:0] val_rd_addr,
    output logic [$clog2(STACK_DEPTH)-1:0] min_rd_addr,
    input  logic [31:0]                    val_rd_data,
    input  logic [31:0]                    min_rd_data
);
    import min_stk_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_RELOAD = 1'b1;

    logic               state_reg, state_next;
    logic [CW-1:0]      val_count_reg, val_count_next;
    logic [CW-1:0]      min_count_reg, min_count_next;
    logic signed [31:0] val_top_reg, val_top_next;
    logic signed [31:0] min_top_reg, min_top_next;
    logic               accept;
    logic               full;
    logic               pop_min;

    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign res_valid = accept;
    assign full      = (val_count_reg == CW'(STACK_DEPTH));

    // Command decode, memory requests and next state
    always_comb begin
        state_next     = state_reg;
        val_count_next = val_count_reg;
        min_count_next = min_count_reg;
        val_top_next   = val_top_reg;
        min_top_next   = min_top_reg;
        res            = '0;
        val_wr_en      = 1'b0;
        min_wr_en      = 1'b0;
        val_wr_addr    = val_count_reg[AW-1:0];
        min_wr_addr    = min_count_reg[AW-1:0];
        rd_en          = 1'b0;
        pop_min        = (min_count_reg != '0) && (min_top_reg == val_top_reg);
        val_rd_addr    = AW'(val_count_reg - CW'(2));
        min_rd_addr    = pop_min ? AW'(min_count_reg - CW'(2))
                                 : AW'(min_count_reg - CW'(1));

        if (state_reg == ST_RELOAD) begin
            // new tops arrive from the memories after a pop
            val_top_next = val_rd_data;
            min_top_next = min_rd_data;
            state_next   = ST_IDLE;
        end else if (accept) begin
            case (req.command)
                CMD_PUSH: begin
                    if (full) begin
                        res.status = ST_FULL;
                    end else begin
                        val_wr_en      = 1'b1;
                        val_top_next   = req.push_value;
                        val_count_next = val_count_reg + CW'(1);
                        if ((min_count_reg == '0 || req.push_value <= min_top_reg)
                            && min_count_reg != CW'(STACK_DEPTH)) begin
                            min_wr_en      = 1'b1;
                            min_top_next   = req.push_value;
                            min_count_next = min_count_reg + CW'(1);
                        end
                    end
                end
                CMD_POP: begin
                    if (val_count_reg == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        val_count_next = val_count_reg - CW'(1);
                        if (pop_min) begin
                            min_count_next = min_count_reg - CW'(1);
                        end
                        rd_en      = 1'b1;
                        state_next = ST_RELOAD;
                    end
                end
                CMD_TOP: begin
                    if (val_count_reg == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.read_value = val_top_reg;
                    end
                end
                default: begin
                    if (val_count_reg == '0 || min_count_reg == '0) begin
                        res.status = ST_EMPTY;
                    end else begin
                        res.read_value = min_top_reg;
                    end
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            val_count_reg <= '0;
            min_count_reg <= '0;
        end else begin
            state_reg     <= state_next;
            val_count_reg <= val_count_next;
            min_count_reg <= min_count_next;
        end
    end

    // Cached tops of both stacks
    always_ff @(posedge aclk) begin
        val_top_reg <= val_top_next;
        min_top_reg <= min_top_next;
    end

    `MIN_STK_ASSERT_IMP(a_min_le_val, 1'b1, min_count_reg <= val_count_reg)
    `MIN_STK_ASSERT_IMP(a_count_bound, 1'b1, val_count_reg <= CW'(STACK_DEPTH))
    `MIN_STK_ASSERT_IMP(a_min_nonempty, val_count_reg != '0, min_count_reg != '0)
    `MIN_STK_ASSERT_IMP(a_reload_stall, state_reg == ST_RELOAD, !req_ready)
    `MIN_STK_ASSERT_NXT(a_pop_reload, rd_en, state_reg == ST_RELOAD)

endmodule

/* src/min_tracking_stack.sv */
// Min tracking stack: signed 32-bit push/pop with running minimum.
// The result is registered on m_data in the cycle after the request is accepted.
// s_ready waits for a free output. Push, top and minimum let the next request in
// at once; a pop holds s_ready low in RELOAD while the tops are read back from memory.
// Reset (aresetn, synchronous): counts and control cleared; memories are not cleared.
module min_tracking_stack #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  min_stk_pkg::min_stk_req_t s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output min_stk_pkg::min_stk_res_t m_data
);
    import min_stk_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    logic          out_free;
    logic          res_valid;
    min_stk_res_t  res;
    logic          m_valid_reg;
    min_stk_res_t  m_data_reg;
    logic          val_wr_en, min_wr_en, rd_en;
    logic [AW-1:0] val_wr_addr, min_wr_addr, val_rd_addr, min_rd_addr;
    logic [31:0]   val_rd_data, min_rd_data;

    assign out_free = !m_valid_reg || m_ready;

    min_stk_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_valid),
        .req_ready   (s_ready),
        .req         (s_data),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .val_wr_en   (val_wr_en),
        .val_wr_addr (val_wr_addr),
        .min_wr_en   (min_wr_en),
        .min_wr_addr (min_wr_addr),
        .rd_en       (rd_en),
        .val_rd_addr (val_rd_addr),
        .min_rd_addr (min_rd_addr),
        .val_rd_data (val_rd_data),
        .min_rd_data (min_rd_data)
    );

    min_stk_mem #(.DEPTH(STACK_DEPTH)) u_val_mem (
        .aclk    (aclk),
        .wr_en   (val_wr_en),
        .wr_addr (val_wr_addr),
        .wr_data (s_data.push_value),
        .rd_en   (rd_en),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data)
    );

    min_stk_mem #(.DEPTH(STACK_DEPTH)) u_min_mem (
        .aclk    (aclk),
        .wr_en   (min_wr_en),
        .wr_addr (min_wr_addr),
        .wr_data (s_data.push_value),
        .rd_en   (rd_en),
        .rd_addr (min_rd_addr),
        .rd_data (min_rd_data)
    );

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;

    import min_stk_pkg::*;

    localparam int STK_DEPTH = 1024;
    localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    // Pending request plus a flag telling the driver to wait for all results first
    typedef struct {
        min_stk_req_t req;
        bit           hold_for_drain;
    } cmd_slot_t;

    logic         aclk    = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    min_stk_req_t s_data  = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    min_stk_res_t m_data;

    cmd_slot_t    cmd_backlog[$];
    min_stk_res_t awaited_results[$];

    // Shadow copy of the two stacks
    logic signed [31:0] value_mem[STK_DEPTH];
    logic signed [31:0] minimum_mem[STK_DEPTH];
    int value_cnt   = 0;
    int minimum_cnt = 0;

    int plan_depth  = 0;
    int fault_count = 0;
    int sent_count  = 0;
    int taken_count = 0;
    int full_hits   = 0;
    int empty_hits  = 0;
    int peak_depth  = 0;
    int min_peak    = 0;
    int cmd_tally[4];

    min_tracking_stack #(.STACK_DEPTH(STK_DEPTH)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Apply one request to the shadow stacks and return the response it should give
    function automatic min_stk_res_t stack_apply(input min_stk_req_t r);
        min_stk_res_t res;
        res.read_value = '0;
        res.status     = ST_OK;
        cmd_tally[r.command]++;
        case (r.command)
            CMD_PUSH: begin
                if (value_cnt >= STK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    value_mem[value_cnt] = r.push_value;
                    value_cnt++;
                    // new value joins the minimum stack when it is at most the current minimum
                    if (minimum_cnt == 0 || r.push_value <= minimum_mem[minimum_cnt - 1]) begin
                        if (minimum_cnt < STK_DEPTH) begin
                            minimum_mem[minimum_cnt] = r.push_value;
                            minimum_cnt++;
                        end
                    end
                end
            end
            CMD_POP: begin
                if (value_cnt == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    if (minimum_cnt > 0 &&
                        minimum_mem[minimum_cnt - 1] == value_mem[value_cnt - 1]) begin
                        minimum_cnt--;
                    end
                    value_cnt--;
                end
            end
            CMD_TOP: begin
                if (value_cnt == 0) res.status = ST_EMPTY;
                else res.read_value = value_mem[value_cnt - 1];
            end
            default: begin
                if (value_cnt == 0 || minimum_cnt == 0) res.status = ST_EMPTY;
                else res.read_value = minimum_mem[minimum_cnt - 1];
            end
        endcase
        if (res.status == ST_FULL) full_hits++;
        if (res.status == ST_EMPTY) empty_hits++;
        if (value_cnt > peak_depth) peak_depth = value_cnt;
        if (minimum_cnt > min_peak) min_peak = minimum_cnt;
        return res;
    endfunction

    // Values: often small so duplicates and ties are common, some extremes, rest full range
    function automatic logic signed [31:0] rand_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 16) - 8;
            4: begin
                case ($urandom_range(0, 3))
                    0: v = VAL_MAX;
                    1: v = VAL_MIN;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_cmd(input int push_pct, input int pop_pct,
                                            input int top_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) return CMD_PUSH;
        if (r < push_pct + pop_pct) return CMD_POP;
        if (r < push_pct + pop_pct + top_pct) return CMD_TOP;
        return CMD_MIN;
    endfunction

    task automatic queue_cmd(input logic [1:0] cmd, input logic signed [31:0] val,
                             input bit hold);
        cmd_slot_t slot;
        slot.req.command    = cmd;
        slot.req.push_value = val;
        slot.hold_for_drain = hold;
        cmd_backlog.insert(cmd_backlog.size(), slot);
        // track depth so the climb phase knows when the stack is full
        if (cmd == CMD_PUSH && plan_depth < STK_DEPTH) plan_depth++;
        if (cmd == CMD_POP && plan_depth > 0) plan_depth--;
    endtask

    // Driver: offers the next pending request, with random idle bursts
    always @(posedge aclk) begin : drive_proc
        bit        offering;
        bit        launch;
        bit        calm;
        cmd_slot_t nxt;
        int        gap_left;
        launch = 1'b0;
        calm   = cmd_backlog.size() < 200;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            gap_left = 0;
        end else begin
            offering = s_valid;
            if (s_valid && s_ready) begin
                awaited_results.insert(awaited_results.size(), stack_apply(s_data));
                sent_count++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (cmd_backlog.size() > 0 &&
                             (!cmd_backlog[0].hold_for_drain ||
                              awaited_results.size() == 0)) begin
                    if (!calm && $urandom_range(0, 9) == 0) begin
                        gap_left = $urandom_range(0, 16);
                    end else begin
                        nxt    = cmd_backlog.pop_front();
                        launch = 1'b1;
                        s_data <= nxt.req;
                    end
                end
                s_valid <= launch;
            end
        end
    end

    // Monitor: checks each response and drives m_ready with stall bursts and one long hold
    always @(posedge aclk) begin : watch_proc
        min_stk_res_t want;
        bit           rdy;
        bit           calm;
        int           stall_left;
        int           hold_left;
        bit           long_hold_done;
        calm = cmd_backlog.size() < 200;
        if (!aresetn) begin
            m_ready        <= 1'b0;
            stall_left     = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                taken_count++;
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected response: expected none, actual value %h status %0d",
                             $time, m_data.read_value, m_data.status);
                    fault_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.read_value !== want.read_value) begin
                        $display("%0t: read_value wrong: expected %h, actual %h",
                                 $time, want.read_value, m_data.read_value);
                        fault_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $display("%0t: status wrong: expected %0d, actual %0d",
                                 $time, want.status, m_data.status);
                        fault_count++;
                    end
                end
            end
            // a single long hold lets the block back up and stall its input
            if (!long_hold_done && sent_count >= 400) begin
                hold_left      = 300;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 16);
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            m_ready <= rdy;
        end
    end

    initial begin
        #5ms;
        $display("min_tracking_stack: mismatch");
        $finish;
    end

    initial begin : stimulus
        bit first;
        for (int k = 0; k < 4; k++) cmd_tally[k] = 0;

        // Directed: empty reads, extremes, duplicate minimum, non-minimum pop
        queue_cmd(CMD_POP,  rand_value(), 1'b0);
        queue_cmd(CMD_TOP,  rand_value(), 1'b0);
        queue_cmd(CMD_MIN,  rand_value(), 1'b0);
        queue_cmd(CMD_PUSH, VAL_MAX, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_TOP,  '1, 1'b0);
        queue_cmd(CMD_PUSH, VAL_MIN, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_PUSH, VAL_MIN, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_TOP,  '0, 1'b0);
        queue_cmd(CMD_PUSH, 32'sd5, 1'b0);
        queue_cmd(CMD_PUSH, 32'sd3, 1'b0);
        queue_cmd(CMD_PUSH, 32'sd5, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);
        queue_cmd(CMD_POP,  '0, 1'b0);
        queue_cmd(CMD_TOP,  '0, 1'b0);
        queue_cmd(CMD_MIN,  '0, 1'b0);

        // Shallow random walk, hits empty often; sender first waits for a full drain
        for (int i = 0; i < 500; i++) queue_cmd(pick_cmd(35, 30, 15), rand_value(), i == 0);

        // Climb to full, then knock on the full stack
        first = 1'b1;
        while (plan_depth < STK_DEPTH) begin
            queue_cmd(pick_cmd(94, 2, 2), rand_value(), first);
            first = 1'b0;
        end
        repeat (6) queue_cmd(CMD_PUSH, rand_value(), 1'b0);

        // Hover around the full boundary
        for (int i = 0; i < 300; i++) queue_cmd(pick_cmd(40, 25, 15), rand_value(), 1'b0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_valid) @(posedge aclk);
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Ran %0d requests (%0d push, %0d pop, %0d top, %0d min), %0d responses checked.",
                 sent_count, cmd_tally[CMD_PUSH], cmd_tally[CMD_POP], cmd_tally[CMD_TOP],
                 cmd_tally[CMD_MIN], taken_count);
        $display("Saw %0d full and %0d empty responses; peak depth %0d, minimum stack peak %0d.",
                 full_hits, empty_hits, peak_depth, min_peak);
        if (fault_count == 0) begin
            $display("min_tracking_stack: match");
        end else begin
            $display("min_tracking_stack: mismatch");
        end
        $finish;
    end

endmodule
